// ===== design/scmd_pkg.sv =====
// Shared types and codes for the serial channel multiplexer/demultiplexer.
// No dependencies; imported by scmd_step and serial_channel_mux_demux_unit.
`timescale 1ns / 1ps

package scmd_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_TX    = 2'd0;
    localparam logic [1:0] CMD_RX    = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DELIMITER  = 2'd0;
    localparam logic [1:0] CFG_RESET_CODE = 2'd1;
    localparam logic [1:0] CFG_CHAN_COUNT = 2'd2;
    localparam logic [1:0] CFG_ID_TABLE   = 2'd3;

    // Destination flag
    localparam logic DEST_LINK    = 1'b0;
    localparam logic DEST_CHANNEL = 1'b1;

    // At most four result words per input word
    localparam int RES_MAX = 4;
    localparam int CNT_W   = 3;
    localparam int PTR_W   = 2;

    typedef struct packed {
        logic [7:0]  delimiter_byte;
        logic [7:0]  reset_code;
        logic [3:0]  channel_count;
        logic [63:0] channel_id_table;
    } cfg_t;

    typedef struct packed {
        logic       tx_announced_valid;
        logic [2:0] tx_announced_index;
        logic       rx_escape_pending;
        logic       rx_channel_valid;
        logic [2:0] rx_channel_index;
    } link_state_t;

    typedef struct packed {
        logic       dest;
        logic [2:0] out_channel;
        logic [7:0] out_byte;
    } result_t;

endpackage

// ===== design/scmd_step.sv =====
// Combinational processing of one command word: result words and next link state.
// Depends on scmd_pkg.
`timescale 1ns / 1ps

module scmd_step #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic [1:0]                               cmd,
    input  logic [2:0]                               channel_index,
    input  logic [7:0]                               data_byte,
    input  scmd_pkg::cfg_t                           cfg,
    input  scmd_pkg::link_state_t                    state,
    output scmd_pkg::link_state_t                    state_next,
    output scmd_pkg::result_t [scmd_pkg::RES_MAX-1:0] results,
    output logic [scmd_pkg::CNT_W-1:0]               result_count
);
    import scmd_pkg::*;

    logic [3:0] active;
    logic       announce;
    logic       dup;
    logic       found;
    logic [2:0] hit;
    logic [7:0] tx_id;
    logic       is_data;

    assign active = (cfg.channel_count > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS)
                                                           : cfg.channel_count;
    assign tx_id  = cfg.channel_id_table[{channel_index, 3'b000} +: 8];
    assign dup    = (data_byte == cfg.delimiter_byte);

    // Lowest matching channel wins
    always_comb
    begin
        found = 1'b0;
        hit   = 3'd0;
        for (int i = MAX_CHANNELS - 1; i >= 0; i--)
        begin
            if ((4'(i) < active) && (cfg.channel_id_table[8*i +: 8] == data_byte))
            begin
                found = 1'b1;
                hit   = 3'(i);
            end
        end
    end

    always_comb
    begin
        state_next   = state;
        result_count = '0;
        announce     = 1'b0;
        is_data      = 1'b0;
        for (int k = 0; k < RES_MAX; k++)
        begin
            results[k] = '{dest: DEST_LINK, out_channel: 3'd0, out_byte: 8'd0};
        end

        case (cmd)
            CMD_TX:
            begin
                if ({1'b0, channel_index} < active)
                begin
                    announce = !state.tx_announced_valid
                               || (state.tx_announced_index != channel_index);
                    state_next.tx_announced_valid = 1'b1;
                    state_next.tx_announced_index = channel_index;
                    if (announce)
                    begin
                        results[0].out_byte = cfg.delimiter_byte;
                        results[1].out_byte = tx_id;
                        results[2].out_byte = data_byte;
                        results[3].out_byte = data_byte;
                        result_count = dup ? CNT_W'(4) : CNT_W'(3);
                    end
                    else
                    begin
                        results[0].out_byte = data_byte;
                        results[1].out_byte = data_byte;
                        result_count = dup ? CNT_W'(2) : CNT_W'(1);
                    end
                end
            end
            CMD_RX:
            begin
                if (state.rx_escape_pending)
                begin
                    state_next.rx_escape_pending = 1'b0;
                    if (dup)
                    begin
                        is_data = 1'b1;
                    end
                    else if (data_byte == cfg.reset_code)
                    begin
                        state_next.tx_announced_valid = 1'b0;
                    end
                    else if (found)
                    begin
                        state_next.rx_channel_valid = 1'b1;
                        state_next.rx_channel_index = hit;
                    end
                    else
                    begin
                        // unknown id: stop delivering and ask the far end to reset
                        state_next.rx_channel_valid = 1'b0;
                        results[0].out_byte = cfg.delimiter_byte;
                        results[1].out_byte = cfg.reset_code;
                        result_count = CNT_W'(2);
                    end
                end
                else if (dup)
                begin
                    state_next.rx_escape_pending = 1'b1;
                end
                else
                begin
                    is_data = 1'b1;
                end

                if (is_data && state.rx_channel_valid)
                begin
                    results[0].dest        = DEST_CHANNEL;
                    results[0].out_channel = state.rx_channel_index;
                    results[0].out_byte    = data_byte;
                    result_count = CNT_W'(1);
                end
            end
            CMD_RESET:
            begin
                results[0].out_byte = cfg.delimiter_byte;
                results[1].out_byte = cfg.reset_code;
                result_count = CNT_W'(2);
            end
            default:
            begin
                result_count = '0;
            end
        endcase
    end

endmodule

// ===== design/serial_channel_mux_demux_unit.sv =====
// Top level of the byte-stuffed serial channel multiplexer/demultiplexer.
// Depends on scmd_pkg and scmd_step.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake           Payload
//  s_*      in         s_tvalid/s_tready   s_tuser = cmd; s_tdata = channel_index, data_byte
//  m_*      out        m_tvalid/m_tready   m_tuser = dest; m_tdata = out_channel, out_byte;
//                                          m_tlast = last
//  cfg_*    in         cfg_valid/cfg_ready cfg_index selects register, cfg_data is the value
//
//  A command word waits in the input register until the result buffer
//  is free, then scmd_step decodes it in one pass into up to four result words, loaded into
//  the buffer with the updated link state. The buffer drains one word per cycle while
//  m_tready is high, reloading in the cycle its final word is taken. rst_n clears the
//  configuration to its defaults, the link state, the input valid flag and the buffer
//  count; cfg is always ready.

module serial_channel_mux_demux_unit #(
    parameter int MAX_CHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] channel_index, [10:3] data_byte, [15:11] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] out_channel, [10:3] out_byte, [15:11] zero
    output logic [0:0]  m_tuser,   // [0] dest
    output logic        m_tlast
);
    import scmd_pkg::*;

    // configuration registers
    cfg_t        cfg_reg;

    // link state
    link_state_t state_reg;
    link_state_t state_next;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [2:0]  in_chan_reg;
    logic [7:0]  in_byte_reg;

    // result buffer
    result_t     res_reg [RES_MAX];
    logic [CNT_W-1:0] cnt_reg;
    logic [PTR_W-1:0] ptr_reg;

    result_t [RES_MAX-1:0] step_results;
    logic [CNT_W-1:0]      step_count;

    logic out_last;
    logic out_take;
    logic advance;
    logic in_take;

    assign cfg_ready = 1'b1;

    // Final word of the buffered group when the pointer reaches count - 1
    assign out_last = ({1'b0, ptr_reg} == (cnt_reg - CNT_W'(1)));
    assign m_tvalid = (cnt_reg != '0);
    assign out_take = m_tvalid && m_tready;

    // Move the held command into the result stage when the buffer is free
    assign advance  = in_valid_reg && ((cnt_reg == '0) || (out_take && out_last));
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign m_tdata  = {5'd0, res_reg[ptr_reg].out_byte, res_reg[ptr_reg].out_channel};
    assign m_tuser  = res_reg[ptr_reg].dest;
    assign m_tlast  = out_last;

    scmd_step #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_step (
        .cmd           (in_cmd_reg),
        .channel_index (in_chan_reg),
        .data_byte     (in_byte_reg),
        .cfg           (cfg_reg),
        .state         (state_reg),
        .state_next    (state_next),
        .results       (step_results),
        .result_count  (step_count)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delimiter_byte   <= 8'd0;
            cfg_reg.reset_code       <= 8'd255;
            cfg_reg.channel_count    <= 4'd1;
            cfg_reg.channel_id_table <= 64'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DELIMITER:  cfg_reg.delimiter_byte   <= cfg_data[7:0];
                CFG_RESET_CODE: cfg_reg.reset_code       <= cfg_data[7:0];
                CFG_CHAN_COUNT: cfg_reg.channel_count    <= cfg_data[3:0];
                CFG_ID_TABLE:   cfg_reg.channel_id_table <= cfg_data;
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register: hold the word until the result stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= s_tuser;
            in_chan_reg <= s_tdata[2:0];
            in_byte_reg <= s_tdata[10:3];
        end
    end

    // Link state advances once per command word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.tx_announced_valid <= 1'b0;
            state_reg.tx_announced_index <= 3'd0;
            state_reg.rx_escape_pending  <= 1'b0;
            state_reg.rx_channel_valid   <= 1'b1;
            state_reg.rx_channel_index   <= 3'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result buffer: load a whole group, drain one word a cycle while m_tready is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end
        else if (advance)
        begin
            cnt_reg <= step_count;
            ptr_reg <= '0;
        end
        else if (out_take)
        begin
            if (out_last)
            begin
                cnt_reg <= '0;
                ptr_reg <= '0;
            end
            else
            begin
                ptr_reg <= ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < RES_MAX; k++)
            begin
                res_reg[k] <= step_results[k];
            end
        end
    end

endmodule
